// ===== rtl/eiscp_pkg.sv =====
// eiscp_pkg: constants, codes and types for the eISCP stream deframer
// no dependencies; used by eiscp_deframer_unit and its bench

package eiscp_pkg;

	localparam int HEADER_BYTES = 16;
	localparam int HOLD_DEPTH   = 8;

	localparam int HDR_IDX_W = 6;
	localparam int HC_W      = $clog2(HOLD_DEPTH + 1);

	localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);
	localparam logic [HC_W-1:0]      HC_FULL  = HC_W'(HOLD_DEPTH);

	localparam logic [31:0] MAGIC_RESET = 32'h4953_4350;

	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SUB  = 8'h1A;

	typedef enum logic [1:0] {
		KIND_DATA      = 2'd0,
		KIND_END       = 2'd1,
		KIND_BAD_MAGIC = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_BODY   = 2'd2
	} pos_t;

	typedef enum logic {
		PH_MAIN = 1'b0,
		PH_END  = 1'b1
	} phase_t;

	typedef struct packed {
		logic       emit;
		kind_t      kind;
		logic [7:0] data;
		logic       done;
		logic       main_done;
		logic       to_end;
		logic       hdr;
		logic       start;
		logic       hunt;
		logic       set_bang;
		logic       clr_bang;
		logic       pos_we;
		pos_t       pos_val;
		logic       push;
		logic       ovf;
		logic       pop;
	} op_t;

	function automatic logic is_term(input logic [7:0] b);
		return (b == CH_CR) || (b == CH_LF) || (b == CH_SUB);
	endfunction

endpackage

// ===== rtl/eiscp_deframer_unit.sv =====
// eiscp_deframer_unit: eISCP byte stream deframer, header check, prefix drop,
// trailing terminator hold; uses eiscp_pkg
//
//  channel | signals                          | direction | payload
//  in      | in_valid, in_ready               | to block  | rx_byte
//  out     | out_valid, out_ready             | from block| kind, data_byte
//  cfg     | cfg_valid, cfg_ready             | to block  | magic_word
//
//  one received byte per cycle through the input register when results drain
//  a byte that releases held terminators waits while they go out, oldest first, on the single
//  result register; end of message adds an end result, preceded by a held '!' if any
//  a lone '!' goes out as a result of its own; header bytes and held terminators add none
//  arst_n clears all control state; magic word resets to ASCII ISCP
//  out_ready low stalls the result register and, through it, the input

module eiscp_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] magic_word
);

	logic                             valid_s1;
	logic [7:0]                       byte_s1;
	logic [31:0]                      magic_word_q;
	logic                             in_payload_q;
	logic [eiscp_pkg::HDR_IDX_W-1:0]  header_index_q;
	logic [31:0]                      magic_shift_q;
	logic [31:0]                      length_shift_q;
	logic [31:0]                      bytes_left_q;
	eiscp_pkg::pos_t                  pos_q;
	logic                             held_bang_q;
	logic [7:0]                       hold_q [eiscp_pkg::HOLD_DEPTH];
	logic [eiscp_pkg::HC_W-1:0]       hold_count_q;
	eiscp_pkg::phase_t                ph_q;
	eiscp_pkg::phase_t                ph_nxt;
	logic                             out_valid_q;
	eiscp_pkg::kind_t                 kind_q;
	logic [7:0]                       data_q;

	eiscp_pkg::op_t op;
	logic           slot_free;
	logic           fire;
	logic           hdr_last;
	logic [31:0]    magic_nxt;
	logic [31:0]    length_nxt;

	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;
	assign fire      = valid_s1 && (!op.emit || slot_free);
	assign in_ready  = !valid_s1 || (fire && op.done);
	assign hdr_last  = (header_index_q == eiscp_pkg::HDR_LAST);

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data_byte = data_q;

	// header shift registers
	always_comb begin
		magic_nxt  = magic_shift_q;
		length_nxt = length_shift_q;
		if (header_index_q < eiscp_pkg::HDR_IDX_W'(4)) begin
			magic_nxt = {magic_shift_q[23:0], byte_s1};
		end else if (header_index_q >= eiscp_pkg::HDR_IDX_W'(8) &&
			header_index_q < eiscp_pkg::HDR_IDX_W'(12)) begin
			length_nxt = {length_shift_q[23:0], byte_s1};
		end
	end

	// per-cycle step decode
	always_comb begin
		op      = '0;
		op.kind = eiscp_pkg::KIND_DATA;
		op.data = '0;
		op.pos_val = eiscp_pkg::POS_FIRST;
		if (valid_s1) begin
			if (ph_q == eiscp_pkg::PH_END) begin
				op.emit = 1'b1;
				if (held_bang_q) begin
					op.data     = eiscp_pkg::CH_BANG;
					op.clr_bang = 1'b1;
				end else begin
					op.kind = eiscp_pkg::KIND_END;
					op.hunt = 1'b1;
					op.done = 1'b1;
				end
			end else if (!in_payload_q) begin
				op.hdr  = 1'b1;
				op.done = 1'b1;
				if (hdr_last) begin
					op.hunt = 1'b1;
					if (magic_nxt != magic_word_q) begin
						op.emit = 1'b1;
						op.kind = eiscp_pkg::KIND_BAD_MAGIC;
					end else if (length_nxt == '0) begin
						op.emit = 1'b1;
						op.kind = eiscp_pkg::KIND_END;
					end else begin
						op.start = 1'b1;
					end
				end
			end else if (pos_q == eiscp_pkg::POS_FIRST && byte_s1 == eiscp_pkg::CH_BANG) begin
				op.set_bang  = 1'b1;
				op.pos_we    = 1'b1;
				op.pos_val   = eiscp_pkg::POS_SECOND;
				op.main_done = 1'b1;
			end else if (pos_q == eiscp_pkg::POS_SECOND && held_bang_q) begin
				op.clr_bang = 1'b1;
				if (byte_s1 == eiscp_pkg::CH_ONE) begin
					op.pos_we    = 1'b1;
					op.pos_val   = eiscp_pkg::POS_BODY;
					op.main_done = 1'b1;
				end else begin
					op.emit = 1'b1;
					op.data = eiscp_pkg::CH_BANG;
				end
			end else if (eiscp_pkg::is_term(byte_s1)) begin
				op.pos_we    = 1'b1;
				op.pos_val   = eiscp_pkg::POS_BODY;
				op.main_done = 1'b1;
				if (hold_count_q == eiscp_pkg::HC_FULL) begin
					op.emit = 1'b1;
					op.data = hold_q[0];
					op.ovf  = 1'b1;
				end else begin
					op.push = 1'b1;
				end
			end else if (hold_count_q != '0) begin
				op.emit = 1'b1;
				op.data = hold_q[0];
				op.pop  = 1'b1;
			end else begin
				op.emit      = 1'b1;
				op.data      = byte_s1;
				op.pos_we    = 1'b1;
				op.pos_val   = eiscp_pkg::POS_BODY;
				op.main_done = 1'b1;
			end
			if (op.main_done) begin
				if (bytes_left_q == 32'd1) begin
					op.to_end = 1'b1;
				end else begin
					op.done = 1'b1;
				end
			end
		end
	end

	// phase next state
	always_comb begin
		ph_nxt = ph_q;
		if (fire) begin
			if (op.to_end) begin
				ph_nxt = eiscp_pkg::PH_END;
			end else if (op.done) begin
				ph_nxt = eiscp_pkg::PH_MAIN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q <= eiscp_pkg::MAGIC_RESET;
		end else if (cfg_valid) begin
			magic_word_q <= magic_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q           <= eiscp_pkg::PH_MAIN;
			in_payload_q   <= 1'b0;
			header_index_q <= '0;
			magic_shift_q  <= '0;
			length_shift_q <= '0;
			bytes_left_q   <= '0;
			pos_q          <= eiscp_pkg::POS_FIRST;
			held_bang_q    <= 1'b0;
			hold_count_q   <= '0;
		end else begin
			ph_q <= ph_nxt;
			if (fire) begin
				if (op.hdr) begin
					magic_shift_q  <= magic_nxt;
					length_shift_q <= length_nxt;
					header_index_q <= hdr_last ? '0 : header_index_q + 1'b1;
				end
				if (op.start) begin
					bytes_left_q <= length_nxt;
				end
				if (op.main_done) begin
					bytes_left_q <= bytes_left_q - 32'd1;
				end
				if (op.set_bang) begin
					held_bang_q <= 1'b1;
				end
				if (op.clr_bang) begin
					held_bang_q <= 1'b0;
				end
				if (op.pos_we) begin
					pos_q <= op.pos_val;
				end
				if (op.push) begin
					hold_count_q <= hold_count_q + 1'b1;
				end
				if (op.pop) begin
					hold_count_q <= hold_count_q - 1'b1;
				end
				if (op.hunt) begin
					in_payload_q   <= 1'b0;
					header_index_q <= '0;
					pos_q          <= eiscp_pkg::POS_FIRST;
					held_bang_q    <= 1'b0;
					hold_count_q   <= '0;
				end
				if (op.start) begin
					in_payload_q <= 1'b1;
				end
			end
		end
	end

	// terminator hold, oldest at entry 0
	always_ff @(posedge clk) begin
		if (fire) begin
			if (op.ovf || op.pop) begin
				for (int i = 0; i < eiscp_pkg::HOLD_DEPTH - 1; i++) begin
					hold_q[i] <= hold_q[i+1];
				end
			end
			if (op.ovf) begin
				hold_q[eiscp_pkg::HOLD_DEPTH-1] <= byte_s1;
			end
			if (op.push) begin
				for (int i = 0; i < eiscp_pkg::HOLD_DEPTH; i++) begin
					if (eiscp_pkg::HC_W'(i) == hold_count_q) begin
						hold_q[i] <= byte_s1;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= fire && op.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && fire && op.emit) begin
			kind_q <= op.kind;
			data_q <= op.data;
		end
	end

	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hold_count_q <= eiscp_pkg::HC_FULL)
		else $error("terminator hold count above depth");

	a_end_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == eiscp_pkg::PH_END |-> in_payload_q && valid_s1)
		else $error("end phase outside a payload request");

	a_bang_pos: assert property (@(posedge clk) disable iff (!arst_n)
		held_bang_q |-> in_payload_q &&
			(pos_q == eiscp_pkg::POS_SECOND || ph_q == eiscp_pkg::PH_END))
		else $error("held bang at wrong payload position");

	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q && ph_q == eiscp_pkg::PH_MAIN |-> bytes_left_q != '0)
		else $error("payload active with no bytes left");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != eiscp_pkg::KIND_DATA |-> data_q == '0)
		else $error("nonzero data on a control result");

endmodule

// ===== sim/eiscp_deframer_unit_tb.sv =====
// eiscp_deframer_unit_tb: self-checking bench for the eISCP stream deframer
// a scoreboard class predicts data, end and bad-header results per received byte;
// needs eiscp_pkg and eiscp_deframer_unit
`timescale 1ns / 100ps

module eiscp_deframer_unit_tb;

	typedef logic [7:0] octet_q_t[$];

	typedef struct packed {
		eiscp_pkg::kind_t kind;
		logic [7:0]       data;
	} frame_result_t;

	class deframe_scoreboard;
		logic [31:0]     magic = eiscp_pkg::MAGIC_RESET;
		bit              in_body;
		int              hdr_pos;
		logic [31:0]     magic_acc;
		logic [31:0]     len_acc;
		logic [31:0]     remaining;
		eiscp_pkg::pos_t pos = eiscp_pkg::POS_FIRST;
		bit              bang;
		logic [7:0]      held[eiscp_pkg::HOLD_DEPTH];
		int              held_n;
		frame_result_t   due_results[$];
		int              errors, n_in, n_data, n_end, n_bad, n_ovf, n_prefix, n_lone;

		function void report(string what);
			$display("mismatch: %s", what);
			errors++;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void emit(eiscp_pkg::kind_t k, logic [7:0] d);
			due_results.push_back('{kind: k, data: d});
			case (k)
				eiscp_pkg::KIND_DATA: n_data++;
				eiscp_pkg::KIND_END:  n_end++;
				default:              n_bad++;
			endcase
		endfunction

		function void restart();
			in_body = 0;
			hdr_pos = 0;
			pos     = eiscp_pkg::POS_FIRST;
			bang    = 0;
			held_n  = 0;
		endfunction

		function void body_byte(logic [7:0] b);
			if (b inside {eiscp_pkg::CH_CR, eiscp_pkg::CH_LF, eiscp_pkg::CH_SUB}) begin
				if (held_n >= eiscp_pkg::HOLD_DEPTH) begin
					emit(eiscp_pkg::KIND_DATA, held[0]);
					for (int i = 1; i < eiscp_pkg::HOLD_DEPTH; i++)
						held[i-1] = held[i];
					held_n = eiscp_pkg::HOLD_DEPTH - 1;
					n_ovf++;
				end
				held[held_n] = b;
				held_n++;
			end else begin
				for (int i = 0; i < held_n; i++)
					emit(eiscp_pkg::KIND_DATA, held[i]);
				held_n = 0;
				emit(eiscp_pkg::KIND_DATA, b);
			end
		endfunction

		function void take_byte(logic [7:0] b);
			n_in++;
			if (!in_body) begin
				if (hdr_pos < 4)
					magic_acc = {magic_acc[23:0], b};
				else if (hdr_pos >= 8 && hdr_pos < 12)
					len_acc = {len_acc[23:0], b};
				hdr_pos++;
				if (hdr_pos >= eiscp_pkg::HEADER_BYTES) begin
					restart();
					if (magic_acc != magic) begin
						emit(eiscp_pkg::KIND_BAD_MAGIC, 8'h00);
					end else if (len_acc == 0) begin
						remaining = 0;
						emit(eiscp_pkg::KIND_END, 8'h00);
					end else begin
						remaining = len_acc;
						in_body   = 1;
					end
				end
				return;
			end
			remaining--;
			case (pos)
				eiscp_pkg::POS_FIRST: begin
					if (b == eiscp_pkg::CH_BANG) begin
						bang = 1;
						pos  = eiscp_pkg::POS_SECOND;
					end else begin
						pos = eiscp_pkg::POS_BODY;
						body_byte(b);
					end
				end
				eiscp_pkg::POS_SECOND: begin
					pos = eiscp_pkg::POS_BODY;
					if (bang && b == eiscp_pkg::CH_ONE) begin
						n_prefix++;
					end else begin
						if (bang) begin
							emit(eiscp_pkg::KIND_DATA, eiscp_pkg::CH_BANG);
							n_lone++;
						end
						body_byte(b);
					end
					bang = 0;
				end
				default: body_byte(b);
			endcase
			if (remaining == 0) begin
				if (bang) begin
					emit(eiscp_pkg::KIND_DATA, eiscp_pkg::CH_BANG);
					n_lone++;
				end
				emit(eiscp_pkg::KIND_END, 8'h00);
				restart();
			end
		endfunction

		function void check_result(eiscp_pkg::kind_t k, logic [7:0] d);
			frame_result_t e;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected result kind %0d data %02h", k, d));
				return;
			end
			e = due_results.pop_front();
			if (k != e.kind)
				report($sformatf("kind %0d, expected %0d", k, e.kind));
			if (d != e.data)
				report($sformatf("data_byte %02h, expected %02h", d, e.data));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] magic_word = 32'h0;

	deframe_scoreboard sb = new();
	int burst_left;
	int stall_pct;
	int rx_tick;
	int n_cfg;

	eiscp_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.magic_word(magic_word)
	);

	always #4 clk = ~clk;

	// receiver: stall level is picked at random from four levels, zero level included
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(eiscp_pkg::kind_t'(kind), data_byte);
		rx_tick++;
		if (rx_tick % 48 == 0)
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 60;
				default: stall_pct = 90;
			endcase
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		sb.take_byte(b);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_magic(input logic [31:0] v);
		cfg_valid  <= 1'b1;
		magic_word <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.magic = v;
		n_cfg++;
	endtask

	task automatic send_header(input logic [31:0] m, input logic [31:0] len);
		for (int i = 0; i < eiscp_pkg::HEADER_BYTES; i++)
			if (i < 4)
				send_byte(m[31-8*i -: 8]);
			else if (i >= 8 && i < 12)
				send_byte(len[31-8*(i-8) -: 8]);
			else
				send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_frame(input logic [31:0] m, input octet_q_t p);
		send_header(m, p.size());
		foreach (p[i])
			send_byte(p[i]);
	endtask

	// realign to a header boundary so the next frame starts clean
	task automatic resync();
		while (sb.in_body || sb.hdr_pos != 0)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] pick_term();
		case ($urandom_range(0, 2))
			0: return eiscp_pkg::CH_CR;
			1: return eiscp_pkg::CH_LF;
			default: return eiscp_pkg::CH_SUB;
		endcase
	endfunction

	function automatic octet_q_t make_payload(int len);
		octet_q_t p;
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			p.push_back(eiscp_pkg::CH_BANG);
			p.push_back(eiscp_pkg::CH_ONE);
		end else if (r < 45) begin
			p.push_back(eiscp_pkg::CH_BANG);
		end
		while (p.size() < len) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				p.push_back(pick_term());
			else if (r < 30)
				repeat ($urandom_range(1, eiscp_pkg::HOLD_DEPTH + 3)) p.push_back(pick_term());
			else if (r < 38)
				p.push_back($urandom_range(0, 1) ? eiscp_pkg::CH_BANG : eiscp_pkg::CH_ONE);
			else
				p.push_back(8'($urandom_range(0, 255)));
		end
		while (p.size() > len)
			void'(p.pop_back());
		return p;
	endfunction

	task automatic directed();
		octet_q_t p;
		send_frame(eiscp_pkg::MAGIC_RESET, p);
		send_header(eiscp_pkg::MAGIC_RESET ^ 32'h0000_0001, 32'hFFFF_FFFF);
		p = {eiscp_pkg::CH_BANG, eiscp_pkg::CH_ONE, "P", "W", "R", "0", "1",
			eiscp_pkg::CH_CR, eiscp_pkg::CH_LF, eiscp_pkg::CH_SUB};
		send_frame(eiscp_pkg::MAGIC_RESET, p);
		p = {eiscp_pkg::CH_BANG, "2", "X"};
		send_frame(eiscp_pkg::MAGIC_RESET, p);
		p = {eiscp_pkg::CH_BANG};
		send_frame(eiscp_pkg::MAGIC_RESET, p);
		drain();
		p = {eiscp_pkg::CH_BANG, eiscp_pkg::CH_ONE};
		send_frame(eiscp_pkg::MAGIC_RESET, p);
		p = {"A", eiscp_pkg::CH_CR, eiscp_pkg::CH_LF, "B"};
		send_frame(eiscp_pkg::MAGIC_RESET, p);
		// overflow released by a later byte, then held terminators dropped at the end after an overflow
		p = {"X"};
		repeat (eiscp_pkg::HOLD_DEPTH + 2) p.push_back(pick_term());
		p.push_back("Y");
		repeat (eiscp_pkg::HOLD_DEPTH + 1) p.push_back(eiscp_pkg::CH_LF);
		send_frame(eiscp_pkg::MAGIC_RESET, p);
		p = {8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA};
		send_frame(eiscp_pkg::MAGIC_RESET, p);
	endtask

	task automatic random_part(input int quota);
		octet_q_t p;
		int start, r, len;
		start = sb.n_in;
		while (sb.n_in - start < quota) begin
			resync();
			if ($urandom_range(0, 9) == 0)
				drain();
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_frame(sb.magic, make_payload(len));
			end else if (r < 80) begin
				send_header(sb.magic ^ (32'h1 << $urandom_range(0, 31)), $urandom);
			end else if (r < 90) begin
				// truncated frame: one byte short of its length; resync fills the missing byte
				send_header(sb.magic, len + 1);
				p = make_payload(len);
				foreach (p[i])
					send_byte(p[i]);
			end else begin
				repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		logic [31:0] settings[3];
		int waited;
		settings = '{eiscp_pkg::MAGIC_RESET, 32'hFFFF_FFFF, $urandom};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (settings[s]) begin
			write_magic(settings[s]);
			if (s == 0)
				directed();
			else
				random_part(10);
			drain();
		end
		in_valid <= 1'b0;
		waited = 0;
		while (sb.pending() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (16) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		$display("run: %0d bytes over %0d magic settings, %0d data, %0d ends, %0d bad headers",
			sb.n_in, n_cfg, sb.n_data, sb.n_end, sb.n_bad);
		$display("     %0d prefix drops, %0d lone bangs, %0d terminator overflows",
			sb.n_prefix, sb.n_lone, sb.n_ovf);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/eiscp_pkg.sv
rtl/eiscp_deframer_unit.sv
sim/eiscp_deframer_unit_tb.sv
